>>> hdl/prq_pkg.sv
// prq_pkg: shared types, codes and field widths of the packet ring queue
`default_nettype none
package prq_pkg;

  // field widths fixed by the transaction format
  localparam int MODE_W   = 3;
  localparam int ADDR_W   = 16;
  localparam int DESC_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  // default queue depth
  localparam int DEF_QUEUE_DEPTH = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCAN   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOACK = 2'd3;

  // one queue slot
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic              pend;
    logic [DESC_W-1:0] desc;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    PRQ_IDLE,
    PRQ_PEEK,
    PRQ_SCAN
  } state_t;

endpackage
`default_nettype wire

>>> hdl/prq_in_if.sv
// prq_in_if: request channel carrying one queue operation per transaction
`default_nettype none
interface prq_in_if;
  logic                        valid;
  logic                        ready;
  logic [prq_pkg::MODE_W-1:0]  mode;
  logic [prq_pkg::ADDR_W-1:0]  source_address;
  logic                        ack_pending;
  logic [prq_pkg::DESC_W-1:0]  descriptor_in;

  modport source (output valid, mode, source_address, ack_pending, descriptor_in,
                  input ready);
  modport sink (input valid, mode, source_address, ack_pending, descriptor_in,
                output ready);
endinterface
`default_nettype wire

>>> hdl/prq_out_if.sv
// prq_out_if: result channel carrying one operation result per transaction
`default_nettype none
interface prq_out_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::STATUS_W-1:0]  status;
  logic [prq_pkg::SLOT_W-1:0]    slot_index;
  logic [prq_pkg::ADDR_W-1:0]    source_address_out;
  logic [prq_pkg::DESC_W-1:0]    descriptor_out;

  modport source (output valid, status, slot_index, source_address_out, descriptor_out,
                  input ready);
  modport sink (input valid, status, slot_index, source_address_out, descriptor_out,
                output ready);
endinterface
`default_nettype wire

>>> hdl/packet_ring_queue_with_ack_scan.sv
// packet_ring_queue_with_ack_scan: circular descriptor queue with ack scan sequencer
//
// Each transaction on in_ch carries one operation: insert, peek head, remove
// head, scan for the next entry pending an ack, or clear. Every operation
// returns exactly one result transaction on out_ch. cfg_we/cfg_wdata write the
// node's own short address, whose packets the scan skips.
// Insert, remove, clear, undefined modes and a scan that starts at the write
// pointer register their result straight from the accepted operation; a peek
// passes the registered read port, then the result register; a scan runs to
// a hit or the write pointer. The scan is set by the single registered read
// port of the slot memory, one slot per cycle, checked by one shared compare.
// in_ch.ready is high only while the sequencer is idle and the result register
// is empty or being drained in the same cycle; one operation is in flight.
// A stalled out_ch holds its result and keeps in_ch.ready low.
// Reset (rst_n low, synchronous) zeroes the pointers, the count and the own
// address; slot contents are not cleared and are only read once written.
`default_nettype none
module packet_ring_queue_with_ack_scan #(
  parameter int QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  prq_in_if.sink                          in_ch,
  prq_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [prq_pkg::ADDR_W-1:0] cfg_wdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0] FULL_CNT  = OW'(QUEUE_DEPTH);

  // slot memory
  prq_pkg::entry_t mem [QUEUE_DEPTH];
  prq_pkg::entry_t rd_data_r;
  logic [PW-1:0]   rd_slot_r;
  logic            mem_we;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;

  // control state
  prq_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [prq_pkg::ADDR_W-1:0] own_r;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic [prq_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [prq_pkg::SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [prq_pkg::ADDR_W-1:0]     res_src_r, res_src_nxt;
  logic [prq_pkg::DESC_W-1:0]     res_desc_r, res_desc_nxt;

  logic in_ready;
  logic in_accept;
  logic scan_hit;

  // wrap-around pointer increment
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = (p == LAST_SLOT) ? '0 : p + 1'b1;
    return q;
  endfunction

  // low three bits of a slot number
  function automatic logic [prq_pkg::SLOT_W-1:0] slot_bits(input logic [PW-1:0] p);
    logic [PW+prq_pkg::SLOT_W-1:0] ext;
    ext = {{prq_pkg::SLOT_W{1'b0}}, p};
    return ext[prq_pkg::SLOT_W-1:0];
  endfunction

  assign in_ready  = (state_r == prq_pkg::PRQ_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // shared compare: entry pending an ack and not from this node
  assign scan_hit = rd_data_r.pend && (rd_data_r.src != own_r);

  // sequencer next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    scan_ptr_nxt   = scan_ptr_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_src_nxt    = res_src_r;
    res_desc_nxt   = res_desc_r;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rd_ptr_r;
    unique case (state_r)
      prq_pkg::PRQ_IDLE: begin
        if (in_accept) begin
          res_status_nxt = prq_pkg::STAT_OK;
          res_slot_nxt   = '0;
          res_src_nxt    = '0;
          res_desc_nxt   = '0;
          out_valid_nxt  = 1'b1;
          unique case (in_ch.mode)
            prq_pkg::MODE_INSERT: begin
              if (occ_r != FULL_CNT) begin
                mem_we     = 1'b1;
                wr_ptr_nxt = adv(wr_ptr_r);
                occ_nxt    = occ_r + 1'b1;
              end else begin
                res_status_nxt = prq_pkg::STAT_FULL;
              end
            end
            prq_pkg::MODE_PEEK: begin
              if (occ_r != '0) begin
                rd_en         = 1'b1;
                rd_addr       = rd_ptr_r;
                out_valid_nxt = 1'b0;
                state_nxt     = prq_pkg::PRQ_PEEK;
              end else begin
                res_status_nxt = prq_pkg::STAT_EMPTY;
              end
            end
            prq_pkg::MODE_REMOVE: begin
              if (occ_r != '0) begin
                rd_ptr_nxt = adv(rd_ptr_r);
                occ_nxt    = occ_r - 1'b1;
              end else begin
                res_status_nxt = prq_pkg::STAT_EMPTY;
              end
            end
            prq_pkg::MODE_SCAN: begin
              if (scan_ptr_r != wr_ptr_r) begin
                rd_en         = 1'b1;
                rd_addr       = scan_ptr_r;
                scan_ptr_nxt  = adv(scan_ptr_r);
                out_valid_nxt = 1'b0;
                state_nxt     = prq_pkg::PRQ_SCAN;
              end else begin
                res_status_nxt = prq_pkg::STAT_NOACK;
              end
            end
            prq_pkg::MODE_CLEAR: begin
              rd_ptr_nxt   = '0;
              wr_ptr_nxt   = '0;
              scan_ptr_nxt = '0;
              occ_nxt      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      prq_pkg::PRQ_PEEK: begin
        res_status_nxt = prq_pkg::STAT_OK;
        res_slot_nxt   = slot_bits(rd_slot_r);
        res_src_nxt    = rd_data_r.src;
        res_desc_nxt   = rd_data_r.desc;
        out_valid_nxt  = 1'b1;
        state_nxt      = prq_pkg::PRQ_IDLE;
      end
      prq_pkg::PRQ_SCAN: begin
        priority if (scan_hit) begin
          res_status_nxt = prq_pkg::STAT_OK;
          res_slot_nxt   = slot_bits(rd_slot_r);
          res_src_nxt    = rd_data_r.src;
          res_desc_nxt   = rd_data_r.desc;
          out_valid_nxt  = 1'b1;
          state_nxt      = prq_pkg::PRQ_IDLE;
        end else if (scan_ptr_r == wr_ptr_r) begin
          res_status_nxt = prq_pkg::STAT_NOACK;
          res_slot_nxt   = '0;
          res_src_nxt    = '0;
          res_desc_nxt   = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = prq_pkg::PRQ_IDLE;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = scan_ptr_r;
          scan_ptr_nxt = adv(scan_ptr_r);
        end
      end
      default: begin
        state_nxt = prq_pkg::PRQ_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prq_pkg::PRQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pointers, count, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      scan_ptr_r  <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // own address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= '0;
    end else if (cfg_we) begin
      own_r <= cfg_wdata;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_src_r    <= res_src_nxt;
    res_desc_r   <= res_desc_nxt;
  end

  // slot memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= '{src: in_ch.source_address, pend: in_ch.ack_pending,
                         desc: in_ch.descriptor_in};
    end
  end

  // slot memory registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_slot_r <= rd_addr;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = res_status_r;
  assign out_ch.slot_index         = res_slot_r;
  assign out_ch.source_address_out = res_src_r;
  assign out_ch.descriptor_out     = res_desc_r;

  // count never passes the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy above queue depth");

  // no result is pending while the sequencer works on a transaction
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != prq_pkg::PRQ_IDLE) |-> !out_valid_r)
    else $error("result pending while sequencer busy");

  // an insert into a non-full queue grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.mode == prq_pkg::MODE_INSERT && occ_r != FULL_CNT)
    |=> occ_r == $past(occ_r) + 1'b1)
    else $error("insert did not advance occupancy");

  // a scan that reaches the write pointer without a hit reports no ack
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prq_pkg::PRQ_SCAN) && !scan_hit && (scan_ptr_r == wr_ptr_r)
    |=> out_valid_r && out_ch.status == prq_pkg::STAT_NOACK)
    else $error("exhausted scan did not report no ack");

endmodule
`default_nettype wire
